### rtl/brle_pkg.sv
// Shared types and constants for the binary run-length encoder.
// No dependencies; used by every module of the block.
package brle_pkg;

    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;
    localparam logic [BYTE_W-1:0]    RUN_MAX      = 8'hFF;
    localparam logic [BYTE_W-1:0]    RUN_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0]    RUN_ONE      = 8'h01;

    // One queued input transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              stream_last;
    } brle_item_t;

    // Head of the input queue as seen by the scanner
    typedef struct packed {
        logic       valid;
        brle_item_t item;
    } brle_head_t;

endpackage

### rtl/brle_front.sv
// Front end of the run-length encoder: accepts input bytes into a short queue.
// Depends on brle_pkg.
module brle_front #(
    parameter int DEPTH = brle_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brle_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          stream_last,
    output brle_pkg::brle_head_t          head,
    input  logic                          pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brle_pkg::brle_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push;
    logic                 do_pop;

    // Flow control
    assign in_stall = (count_reg == CNT_W'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store accepted transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data_byte: data_byte, stream_last: stream_last};
        end
    end

endmodule

### rtl/brle_back.sv
// Back end of the run-length encoder: bit-serial scanner with output register.
// Depends on brle_pkg; fed by brle_front.
module brle_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brle_pkg::brle_head_t          head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brle_pkg::BYTE_W-1:0]   run_length,
    output logic                          item_done,
    output logic                          stream_done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    state_t                             state_reg, state_next;
    logic [brle_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic                               last_reg, last_next;
    logic [brle_pkg::BIT_IDX_W-1:0]     idx_reg, idx_next;
    logic [brle_pkg::BYTE_W-1:0]        cnt_reg, cnt_next;
    logic                               bit_reg, bit_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [brle_pkg::BYTE_W-1:0]        pend_len_reg, pend_len_next;
    logic                               pend_stream_reg, pend_stream_next;
    logic                               out_valid_reg, out_valid_next;
    logic [brle_pkg::BYTE_W-1:0]        out_len_reg, out_len_next;
    logic                               out_item_reg, out_item_next;
    logic                               out_stream_reg, out_stream_next;

    logic                               out_free;
    logic                               new_res;
    logic [brle_pkg::BYTE_W-1:0]        new_len;
    logic                               new_stream;
    logic                               final_step;
    logic                               advance;
    logic                               load;
    logic                               cur_bit;

    assign out_free    = !out_valid_reg || !out_stall;
    assign cur_bit     = byte_reg[brle_pkg::BYTE_W-1];
    assign out_valid   = out_valid_reg;
    assign run_length  = out_len_reg;
    assign item_done   = out_item_reg;
    assign stream_done = out_stream_reg;

    always_comb
    begin
        state_next       = state_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        bit_next         = bit_reg;
        pend_valid_next  = pend_valid_reg;
        pend_len_next    = pend_len_reg;
        pend_stream_next = pend_stream_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_len_next     = out_len_reg;
        out_item_next    = out_item_reg;
        out_stream_next  = out_stream_reg;
        new_res          = 1'b0;
        new_len          = brle_pkg::RUN_ZERO;
        new_stream       = 1'b0;
        final_step       = 1'b0;
        advance          = 1'b0;
        load             = 1'b0;
        pop              = 1'b0;

        // Decide one bit (or one extra result) per cycle while the output is free
        case (state_reg)
            ST_IDLE:
            begin
                load = 1'b1;
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (cur_bit != bit_reg)
                    begin
                        new_res  = 1'b1;
                        new_len  = cnt_reg;
                        cnt_next = brle_pkg::RUN_ONE;
                        bit_next = !bit_reg;
                        advance  = 1'b1;
                    end
                    else if (cnt_reg == brle_pkg::RUN_MAX)
                    begin
                        new_res    = 1'b1;
                        new_len    = brle_pkg::RUN_MAX;
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        advance  = 1'b1;
                    end
                end
            end
            ST_SPLIT:
            begin
                if (out_free)
                begin
                    new_res  = 1'b1;
                    new_len  = brle_pkg::RUN_ZERO;
                    cnt_next = brle_pkg::RUN_ONE;
                    advance  = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    new_res    = 1'b1;
                    new_len    = cnt_reg;
                    new_stream = 1'b1;
                    cnt_next   = brle_pkg::RUN_ZERO;
                    bit_next   = 1'b0;
                    final_step = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_len_next    = pend_len_reg;
                    out_item_next   = 1'b1;
                    out_stream_next = pend_stream_reg;
                    pend_valid_next = 1'b0;
                    load            = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Move to the next bit, or past the byte
        if (advance)
        begin
            byte_next = byte_reg << 1;
            idx_next  = idx_reg + 1'b1;
            if (idx_reg == brle_pkg::LAST_BIT_IDX)
            begin
                if (last_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    final_step = 1'b1;
                end
            end
            else
            begin
                state_next = ST_SCAN;
            end
        end

        // Hold one result back so the last one of a byte can carry item_done
        if (final_step)
        begin
            if (pend_valid_reg && new_res)
            begin
                out_valid_next   = 1'b1;
                out_len_next     = pend_len_reg;
                out_item_next    = 1'b0;
                out_stream_next  = pend_stream_reg;
                pend_len_next    = new_len;
                pend_stream_next = new_stream;
                state_next       = ST_DRAIN;
            end
            else if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_len_next    = pend_len_reg;
                out_item_next   = 1'b1;
                out_stream_next = pend_stream_reg;
                pend_valid_next = 1'b0;
                load            = 1'b1;
            end
            else if (new_res)
            begin
                out_valid_next  = 1'b1;
                out_len_next    = new_len;
                out_item_next   = 1'b1;
                out_stream_next = new_stream;
                load            = 1'b1;
            end
            else
            begin
                load = 1'b1;
            end
        end
        else if (new_res)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_len_next    = pend_len_reg;
                out_item_next   = 1'b0;
                out_stream_next = pend_stream_reg;
            end
            pend_valid_next  = 1'b1;
            pend_len_next    = new_len;
            pend_stream_next = new_stream;
        end

        // Take the next byte from the queue
        if (load)
        begin
            if (head.valid)
            begin
                pop        = 1'b1;
                byte_next  = head.item.data_byte;
                last_next  = head.item.stream_last;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            byte_reg        <= '0;
            last_reg        <= 1'b0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            bit_reg         <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_len_reg    <= '0;
            pend_stream_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_len_reg     <= '0;
            out_item_reg    <= 1'b0;
            out_stream_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_reg        <= byte_next;
            last_reg        <= last_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            bit_reg         <= bit_next;
            pend_valid_reg  <= pend_valid_next;
            pend_len_reg    <= pend_len_next;
            pend_stream_reg <= pend_stream_next;
            out_valid_reg   <= out_valid_next;
            out_len_reg     <= out_len_next;
            out_item_reg    <= out_item_next;
            out_stream_reg  <= out_stream_next;
        end
    end

endmodule

### rtl/binary_run_length_encoder_core.sv
// Binary run-length encoder. Bytes are queued on entry (QUEUE_DEPTH entries) and
// scanned MSB first, one bit per clock; the
// scanner loads the next byte in the same cycle that it finishes the current one.
// A run that passes 255 is split by an added zero-length result, and the byte
// flagged last adds a step for the final count. A byte that ends on a new result
// while an earlier result is still held adds a drain step for it. That new
// result may come from the final bit closing or splitting a run, or from the
// final count of a stream that already gave a result in its last byte.
// The rate is set by the bit-serial scanner; a stall on the output holds it.
// Runs alternate zeros then ones starting with zeros; item_done marks the last
// result of a byte and stream_done the final count of a stream.
// Depends on brle_pkg, brle_front and brle_back.
module binary_run_length_encoder_core #(
    parameter int QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brle_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          stream_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brle_pkg::BYTE_W-1:0]   run_length,
    output logic                          item_done,
    output logic                          stream_done
);

    brle_pkg::brle_head_t head;
    logic                 pop;

    // Input queue
    brle_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .stream_last (stream_last),
        .head        (head),
        .pop         (pop)
    );

    // Bit scanner and output register
    brle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .run_length  (run_length),
        .item_done   (item_done),
        .stream_done (stream_done)
    );

endmodule

### rtl/brle_checker.sv
// Port-level checks for the run-length encoder, bound to the top level.
// Depends on brle_pkg and binary_run_length_encoder_core.
module brle_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [brle_pkg::BYTE_W-1:0]   run_length,
    input logic                          item_done,
    input logic                          stream_done
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(run_length)
            && $stable(item_done) && $stable(stream_done))
        else $error("output transaction changed while stalled");

    // The final count of a stream closes its byte
    a_stream_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> item_done)
        else $error("stream_done without item_done");

    // The final count always covers at least one bit
    a_flush_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_length != '0)
        else $error("final run count is zero");

    // No second stream end directly follows an accepted one
    a_stream_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && stream_done |=> !(out_valid && stream_done))
        else $error("back-to-back stream ends");

endmodule

bind binary_run_length_encoder_core brle_checker u_brle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .run_length  (run_length),
    .item_done   (item_done),
    .stream_done (stream_done)
);
